// ===== sv/hrbp_pkg.sv =====
// Shared types, codes and character classes for the HTTP request byte parser.
package hrbp_pkg;

    localparam int STEP_W = 5;

    // Parser states.
    localparam logic [STEP_W-1:0] ST_METHOD_FIRST = 5'd0;
    localparam logic [STEP_W-1:0] ST_METHOD       = 5'd1;
    localparam logic [STEP_W-1:0] ST_URI          = 5'd2;
    localparam logic [STEP_W-1:0] ST_H            = 5'd3;
    localparam logic [STEP_W-1:0] ST_T1           = 5'd4;
    localparam logic [STEP_W-1:0] ST_T2           = 5'd5;
    localparam logic [STEP_W-1:0] ST_P            = 5'd6;
    localparam logic [STEP_W-1:0] ST_SLASH        = 5'd7;
    localparam logic [STEP_W-1:0] ST_MAJ_FIRST    = 5'd8;
    localparam logic [STEP_W-1:0] ST_MAJ          = 5'd9;
    localparam logic [STEP_W-1:0] ST_MIN_FIRST    = 5'd10;
    localparam logic [STEP_W-1:0] ST_MIN          = 5'd11;
    localparam logic [STEP_W-1:0] ST_LF_LINE      = 5'd12;
    localparam logic [STEP_W-1:0] ST_HDR_START    = 5'd13;
    localparam logic [STEP_W-1:0] ST_HDR_SPACE    = 5'd14;
    localparam logic [STEP_W-1:0] ST_HDR_NAME     = 5'd15;
    localparam logic [STEP_W-1:0] ST_HDR_SP       = 5'd16;
    localparam logic [STEP_W-1:0] ST_HDR_VALUE    = 5'd17;
    localparam logic [STEP_W-1:0] ST_LF_HDR       = 5'd18;
    localparam logic [STEP_W-1:0] ST_LF_END       = 5'd19;

    // Status codes.
    localparam logic [1:0] STAT_PROGRESS = 2'd0;
    localparam logic [1:0] STAT_SUCCESS  = 2'd1;
    localparam logic [1:0] STAT_FAIL     = 2'd2;

    // Field kinds.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_URI    = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;
    localparam logic [2:0] KIND_VALUE  = 3'd4;

    // Operations.
    localparam logic OP_PARSE   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Characters.
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_CTL_HI = 8'h1f;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] field_kind;
        logic       new_header;
        logic [7:0] data_byte;
    } t_result;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_CTL_HI) || (c == CH_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        r = 1'b0;
        case (c) inside
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09, 8'h3f:
                r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== sv/hrbp_in_if.sv =====
// Request byte channel: valid/ready handshake with op and byte payload.
interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_in;

    modport source (output valid, output op, output byte_in, input ready);
    modport sink (input valid, input op, input byte_in, output ready);
endinterface

// ===== sv/hrbp_out_if.sv =====
// Parse result channel: valid/ready handshake with the per-byte result payload.
interface hrbp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] field_kind;
    logic       new_header;
    logic [7:0] data_byte;
    logic [7:0] version_major;
    logic [7:0] version_minor;

    modport source (output valid, output status, output field_kind, output new_header,
                    output data_byte, output version_major, output version_minor,
                    input ready);
    modport sink (input valid, input status, input field_kind, input new_header,
                  input data_byte, input version_major, input version_minor,
                  output ready);
endinterface

// ===== sv/hrbp_step.sv =====
// Next-state and result logic of the request parser for one byte.
module hrbp_step #(
    parameter int VERSION_WIDTH = 8
) (
    input  logic                              i_op,
    input  logic [7:0]                        i_byte,
    input  logic [hrbp_pkg::STEP_W-1:0]       i_step,
    input  logic                              i_header_seen,
    input  logic [VERSION_WIDTH-1:0]          i_major,
    input  logic [VERSION_WIDTH-1:0]          i_minor,
    output logic [hrbp_pkg::STEP_W-1:0]       o_step,
    output logic                              o_header_seen,
    output logic [VERSION_WIDTH-1:0]          o_major,
    output logic [VERSION_WIDTH-1:0]          o_minor,
    output hrbp_pkg::t_result                 o_result
);

    localparam int SUM_W = VERSION_WIDTH + 4;

    logic [3:0]               w_digit;
    logic [SUM_W-1:0]         w_maj_sum;
    logic [SUM_W-1:0]         w_min_sum;
    logic [VERSION_WIDTH-1:0] w_maj_add;
    logic [VERSION_WIDTH-1:0] w_min_add;
    logic                     w_ws;
    logic [1:0]               n_status;
    logic [2:0]               n_kind;
    logic                     n_fresh;

    // Value times ten plus digit, clamped at the counter's maximum.
    assign w_digit   = i_byte[3:0];
    assign w_maj_sum = SUM_W'({i_major, 3'b000}) + SUM_W'({i_major, 1'b0}) + SUM_W'(w_digit);
    assign w_min_sum = SUM_W'({i_minor, 3'b000}) + SUM_W'({i_minor, 1'b0}) + SUM_W'(w_digit);
    assign w_maj_add = (w_maj_sum[SUM_W-1:VERSION_WIDTH] != '0) ? '1
                                                                : w_maj_sum[VERSION_WIDTH-1:0];
    assign w_min_add = (w_min_sum[SUM_W-1:VERSION_WIDTH] != '0) ? '1
                                                                : w_min_sum[VERSION_WIDTH-1:0];
    assign w_ws = (i_byte == hrbp_pkg::CH_SPACE) || (i_byte == hrbp_pkg::CH_TAB);

    always_comb begin
        o_step        = i_step;
        o_header_seen = i_header_seen;
        o_major       = i_major;
        o_minor       = i_minor;
        n_status      = hrbp_pkg::STAT_PROGRESS;
        n_kind        = hrbp_pkg::KIND_NONE;
        n_fresh       = 1'b0;

        if (i_op == hrbp_pkg::OP_RESTART) begin
            o_step        = hrbp_pkg::ST_METHOD_FIRST;
            o_header_seen = 1'b0;
            o_major       = '0;
            o_minor       = '0;
        end else begin
            unique case (i_step)
                hrbp_pkg::ST_METHOD_FIRST: begin
                    if (hrbp_pkg::is_token(i_byte)) begin
                        o_step = hrbp_pkg::ST_METHOD;
                        n_kind = hrbp_pkg::KIND_METHOD;
                    end else begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end
                end
                hrbp_pkg::ST_METHOD: begin
                    if (i_byte == hrbp_pkg::CH_SPACE) o_step = hrbp_pkg::ST_URI;
                    else if (hrbp_pkg::is_token(i_byte)) n_kind = hrbp_pkg::KIND_METHOD;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_URI: begin
                    if (i_byte == hrbp_pkg::CH_SPACE) o_step = hrbp_pkg::ST_H;
                    else if (hrbp_pkg::is_ctl(i_byte)) n_status = hrbp_pkg::STAT_FAIL;
                    else n_kind = hrbp_pkg::KIND_URI;
                end
                hrbp_pkg::ST_H: begin
                    if (i_byte == hrbp_pkg::CH_H) o_step = hrbp_pkg::ST_T1;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_T1: begin
                    if (i_byte == hrbp_pkg::CH_T) o_step = hrbp_pkg::ST_T2;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_T2: begin
                    if (i_byte == hrbp_pkg::CH_T) o_step = hrbp_pkg::ST_P;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_P: begin
                    if (i_byte == hrbp_pkg::CH_P) o_step = hrbp_pkg::ST_SLASH;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_SLASH: begin
                    if (i_byte == hrbp_pkg::CH_SLASH) begin
                        o_major = '0;
                        o_minor = '0;
                        o_step  = hrbp_pkg::ST_MAJ_FIRST;
                    end else begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end
                end
                hrbp_pkg::ST_MAJ_FIRST: begin
                    if (hrbp_pkg::is_digit(i_byte)) begin
                        o_major = w_maj_add;
                        o_step  = hrbp_pkg::ST_MAJ;
                    end else begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end
                end
                hrbp_pkg::ST_MAJ: begin
                    if (i_byte == hrbp_pkg::CH_DOT) o_step = hrbp_pkg::ST_MIN_FIRST;
                    else if (hrbp_pkg::is_digit(i_byte)) o_major = w_maj_add;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_MIN_FIRST: begin
                    if (hrbp_pkg::is_digit(i_byte)) begin
                        o_minor = w_min_add;
                        o_step  = hrbp_pkg::ST_MIN;
                    end else begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end
                end
                hrbp_pkg::ST_MIN: begin
                    if (i_byte == hrbp_pkg::CH_CR) o_step = hrbp_pkg::ST_LF_LINE;
                    else if (hrbp_pkg::is_digit(i_byte)) o_minor = w_min_add;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_LF_LINE: begin
                    if (i_byte == hrbp_pkg::CH_LF) o_step = hrbp_pkg::ST_HDR_START;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_HDR_START: begin
                    // Leading white space folds the line into the previous header value.
                    if (i_byte == hrbp_pkg::CH_CR) begin
                        o_step = hrbp_pkg::ST_LF_END;
                    end else if (i_header_seen && w_ws) begin
                        o_step = hrbp_pkg::ST_HDR_SPACE;
                    end else if (hrbp_pkg::is_token(i_byte)) begin
                        o_header_seen = 1'b1;
                        n_kind        = hrbp_pkg::KIND_NAME;
                        n_fresh       = 1'b1;
                        o_step        = hrbp_pkg::ST_HDR_NAME;
                    end else begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end
                end
                hrbp_pkg::ST_HDR_SPACE: begin
                    if (i_byte == hrbp_pkg::CH_CR) begin
                        o_step = hrbp_pkg::ST_LF_HDR;
                    end else if (w_ws) begin
                        o_step = i_step;
                    end else if (hrbp_pkg::is_ctl(i_byte)) begin
                        n_status = hrbp_pkg::STAT_FAIL;
                    end else begin
                        n_kind = hrbp_pkg::KIND_VALUE;
                        o_step = hrbp_pkg::ST_HDR_VALUE;
                    end
                end
                hrbp_pkg::ST_HDR_NAME: begin
                    if (i_byte == hrbp_pkg::CH_COLON) o_step = hrbp_pkg::ST_HDR_SP;
                    else if (hrbp_pkg::is_token(i_byte)) n_kind = hrbp_pkg::KIND_NAME;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_HDR_SP: begin
                    if (i_byte == hrbp_pkg::CH_SPACE) o_step = hrbp_pkg::ST_HDR_VALUE;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_HDR_VALUE: begin
                    if (i_byte == hrbp_pkg::CH_CR) o_step = hrbp_pkg::ST_LF_HDR;
                    else if (hrbp_pkg::is_ctl(i_byte)) n_status = hrbp_pkg::STAT_FAIL;
                    else n_kind = hrbp_pkg::KIND_VALUE;
                end
                hrbp_pkg::ST_LF_HDR: begin
                    if (i_byte == hrbp_pkg::CH_LF) o_step = hrbp_pkg::ST_HDR_START;
                    else n_status = hrbp_pkg::STAT_FAIL;
                end
                hrbp_pkg::ST_LF_END: begin
                    n_status = (i_byte == hrbp_pkg::CH_LF) ? hrbp_pkg::STAT_SUCCESS
                                                           : hrbp_pkg::STAT_FAIL;
                end
                default: begin
                    n_status = hrbp_pkg::STAT_FAIL;
                end
            endcase
        end

        o_result.status     = n_status;
        o_result.field_kind = n_kind;
        o_result.new_header = n_fresh;
        o_result.data_byte  = (n_kind != hrbp_pkg::KIND_NONE) ? i_byte : 8'h00;
    end

endmodule

// ===== sv/http_request_byte_parser.sv =====
// Top level of the HTTP request byte parser: input register, parse step, result register.
//
// The parser takes one request byte per transfer and returns one result per byte, at a
// sustained rate of one byte per clock cycle while the result side does not stall. A byte
// is captured in the input register, then the parse step logic updates the 20-state
// machine and version counters and writes the result register. The rate is set by the
// state register loop, which closes through the combinational parse step. A stalled result
// register holds the input register, and the input side stays ready as long as the
// pipeline can move. There is no clearing pass after reset; a restart transfer (op set)
// returns the machine to its initial state at any time.
module http_request_byte_parser #(
    parameter int VERSION_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrbp_in_if.sink           i_req,
    hrbp_out_if.source        o_res
);

    logic                         r_in_valid;
    logic                         r_in_op;
    logic [7:0]                   r_in_byte;

    logic [hrbp_pkg::STEP_W-1:0]  r_step;
    logic                         r_header_seen;
    logic [VERSION_WIDTH-1:0]     r_major;
    logic [VERSION_WIDTH-1:0]     r_minor;

    logic                         r_out_valid;
    hrbp_pkg::t_result            r_out;
    logic [7:0]                   r_out_major;
    logic [7:0]                   r_out_minor;

    logic [hrbp_pkg::STEP_W-1:0]  n_step;
    logic                         n_header_seen;
    logic [VERSION_WIDTH-1:0]     n_major;
    logic [VERSION_WIDTH-1:0]     n_minor;
    hrbp_pkg::t_result            n_result;

    logic                         w_move;

    // The held byte moves to the result register when that register is free or draining.
    assign w_move      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_move;

    hrbp_step #(
        .VERSION_WIDTH (VERSION_WIDTH)
    ) u_step (
        .i_op          (r_in_op),
        .i_byte        (r_in_byte),
        .i_step        (r_step),
        .i_header_seen (r_header_seen),
        .i_major       (r_major),
        .i_minor       (r_minor),
        .o_step        (n_step),
        .o_header_seen (n_header_seen),
        .o_major       (n_major),
        .o_minor       (n_minor),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_op   <= i_req.op;
            r_in_byte <= i_req.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= hrbp_pkg::ST_METHOD_FIRST;
            r_header_seen <= 1'b0;
            r_major       <= '0;
            r_minor       <= '0;
        end else if (w_move) begin
            r_step        <= n_step;
            r_header_seen <= n_header_seen;
            r_major       <= n_major;
            r_minor       <= n_minor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out       <= n_result;
            r_out_major <= 8'(n_major);
            r_out_minor <= 8'(n_minor);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.field_kind    = r_out.field_kind;
    assign o_res.new_header    = r_out.new_header;
    assign o_res.data_byte     = r_out.data_byte;
    assign o_res.version_major = r_out_major;
    assign o_res.version_minor = r_out_minor;

    // The machine never leaves the defined states.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= hrbp_pkg::ST_LF_END)
        else $error("parse state outside the defined range");

    // A failed byte leaves the parse state and counters untouched.
    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_result.status == hrbp_pkg::STAT_FAIL)
        |=> (r_step == $past(r_step)) && (r_major == $past(r_major))
            && (r_minor == $past(r_minor)) && (r_header_seen == $past(r_header_seen)))
        else $error("failed byte changed the parse state");

    // A restart returns to the initial state with cleared counters.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in_op == hrbp_pkg::OP_RESTART)
        |=> (r_step == hrbp_pkg::ST_METHOD_FIRST) && !r_header_seen
            && (r_major == '0) && (r_minor == '0))
        else $error("restart did not clear the parser");

    // A byte held in the input register is not overwritten while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_move) |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_op))
        else $error("input register lost a byte under stall");

    // The header start flag only ever marks a header name byte.
    a_new_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.new_header) |-> (r_out.field_kind == hrbp_pkg::KIND_NAME))
        else $error("new header flag on a byte that is not a header name");

endmodule
